// ===== src/pftb_pkg.sv =====
package pftb_pkg;

  localparam int FLOWS      = 16;
  localparam int IDX_W      = (FLOWS > 1) ? $clog2(FLOWS) : 1;
  localparam int PORT_W     = 16;
  localparam int TIME_W     = 64;
  localparam int CARRY_W    = 30;
  localparam int BUCKET_W   = 16;
  localparam int RATE_W     = 30;
  localparam int CNT_W      = 64;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 30;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CARRY_W-1:0] NS_PER_SEC = CARRY_W'(1000000000);

  localparam logic [BUCKET_W-1:0] BUCKET_RESET = BUCKET_W'(100);
  localparam logic [RATE_W-1:0]   RATE_RESET   = RATE_W'(1000);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BUCKET = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_RATE   = CFG_IDX_W'(1);

  typedef enum logic [2:0] {
    OUT_KNOWN_ADMIT = 3'd0,
    OUT_KNOWN_DROP  = 3'd1,
    OUT_NEW_FLOW    = 3'd2,
    OUT_TABLE_FULL  = 3'd3,
    OUT_DISABLED    = 3'd4
  } outcome_t;

  // item as classified by the front end
  typedef struct packed {
    logic [PORT_W-1:0] port;
    logic [TIME_W-1:0] now;
    logic              disabled;
  } item_t;

  // one flow table entry
  typedef struct packed {
    logic [PORT_W-1:0]   port;
    logic [TIME_W-1:0]   stamp;
    logic [CARRY_W-1:0]  carry;
    logic [BUCKET_W-1:0] tokens;
    logic [CNT_W-1:0]    sent;
    logic [CNT_W-1:0]    dropped;
  } entry_t;

  // queue handshake between front and back
  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_head_t;

endpackage

// ===== src/pftb_pkt_if.sv =====
interface pftb_pkt_if import pftb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [PORT_W-1:0] flow_port;
  logic [TIME_W-1:0] now_ns;
  modport source (output valid, flow_port, now_ns, input ready);
  modport sink (input valid, flow_port, now_ns, output ready);
endinterface

// ===== src/pftb_res_if.sv =====
interface pftb_res_if import pftb_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                admit;
  logic [2:0]          outcome;
  logic [BUCKET_W-1:0] tokens_left;
  logic [CNT_W-1:0]    sent_count;
  logic [CNT_W-1:0]    drop_count;
  modport source (output valid, admit, outcome, tokens_left, sent_count, drop_count,
                  input ready);
  modport sink (input valid, admit, outcome, tokens_left, sent_count, drop_count,
                output ready);
endinterface

// ===== src/pftb_cfg_if.sv =====
interface pftb_cfg_if import pftb_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== src/pftb_front.sv =====
module pftb_front import pftb_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  pftb_pkt_if.sink            pkt,
  input  logic [BUCKET_W-1:0] bucket_size,
  output queue_head_t         head,
  input  logic                pop
);

  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);
  localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  item_t               slots [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;
  logic                push;
  logic                do_pop;
  item_t               incoming;

  assign pkt.ready = (count < CNT_BITS'(QUEUE_DEPTH));
  assign push      = pkt.valid && pkt.ready;
  assign do_pop    = pop && (count != '0);

  // classify: a zero bucket drops everything
  always_comb begin
    incoming.port     = pkt.flow_port;
    incoming.now      = pkt.now_ns;
    incoming.disabled = (bucket_size == '0);
  end

  assign head.valid = (count != '0);
  assign head.item  = slots[rd_ptr];

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CNT_BITS'(push) - CNT_BITS'(do_pop);
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= incoming;
    end
  end

endmodule

// ===== src/pftb_div.sv =====
module pftb_div import pftb_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [TIME_W-1:0]  dividend,
  output logic               done,
  output logic [TIME_W-1:0]  quot,
  output logic [CARRY_W-1:0] rem
);

  // division by one second through a reciprocal multiply, floor(2**93 / 1e9),
  // four 32x32 partial products on one shared multiplier, then one correction
  localparam logic [63:0] RECIP   = 64'd9903520314283042199;
  localparam int          Q_W     = 35;
  localparam logic [31:0] NS_WIDE = 32'(NS_PER_SEC);

  typedef enum logic [2:0] {
    D_IDLE, D_PP0, D_PP1, D_PP2, D_PP3, D_QUOT, D_REM, D_FIX
  } dstate_t;

  dstate_t           dstate;
  logic [TIME_W-1:0] num;
  logic [127:0]      acc;
  logic [31:0]       op_a;
  logic [31:0]       op_b;
  logic [63:0]       pp;
  logic [127:0]      pp_shifted;
  logic [Q_W-1:0]    q_est;
  logic [31:0]       r_est;

  // operand select for the shared multiplier
  always_comb begin
    op_a = num[31:0];
    op_b = RECIP[31:0];
    unique case (dstate)
      D_PP1: begin
        op_b = RECIP[63:32];
      end
      D_PP2: begin
        op_a = num[63:32];
      end
      D_PP3: begin
        op_a = num[63:32];
        op_b = RECIP[63:32];
      end
      D_REM: begin
        op_a = q_est[31:0];
        op_b = NS_WIDE;
      end
      default: ;
    endcase
  end

  assign pp = 64'(op_a) * 64'(op_b);

  // align the partial product
  always_comb begin
    unique case (dstate)
      D_PP0:        pp_shifted = {64'b0, pp};
      D_PP1, D_PP2: pp_shifted = {32'b0, pp, 32'b0};
      D_PP3:        pp_shifted = {pp, 64'b0};
      default:      pp_shifted = '0;
    endcase
  end

  // sequence and done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      dstate <= D_IDLE;
      done   <= 1'b0;
    end else begin
      done <= (dstate == D_FIX);
      unique case (dstate)
        D_IDLE: begin
          if (start) begin
            dstate <= D_PP0;
          end
        end
        D_PP0:   dstate <= D_PP1;
        D_PP1:   dstate <= D_PP2;
        D_PP2:   dstate <= D_PP3;
        D_PP3:   dstate <= D_QUOT;
        D_QUOT:  dstate <= D_REM;
        D_REM:   dstate <= D_FIX;
        D_FIX:   dstate <= D_IDLE;
        default: dstate <= D_IDLE;
      endcase
    end
  end

  // estimate is low by at most one, the remainder fits in 32 bits
  always_ff @(posedge clk) begin
    unique case (dstate)
      D_IDLE: begin
        if (start) begin
          num <= dividend;
          acc <= '0;
        end
      end
      D_PP0, D_PP1, D_PP2, D_PP3: begin
        acc <= acc + pp_shifted;
      end
      D_QUOT: begin
        q_est <= acc[127:93];
      end
      D_REM: begin
        r_est <= num[31:0] - pp[31:0];
      end
      D_FIX: begin
        if (r_est >= NS_WIDE) begin
          quot <= TIME_W'(q_est) + 1'b1;
          rem  <= CARRY_W'(r_est - NS_WIDE);
        end else begin
          quot <= TIME_W'(q_est);
          rem  <= r_est[CARRY_W-1:0];
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== src/pftb_back.sv =====
module pftb_back import pftb_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  queue_head_t         head,
  output logic                pop,
  input  logic [BUCKET_W-1:0] bucket_size,
  input  logic [RATE_W-1:0]   refill_rate,
  pftb_res_if.source          res
);

  typedef enum logic [3:0] {
    S_IDLE, S_SRCH, S_SCHK, S_DECIDE, S_DIV1, S_MUL, S_DIV2, S_UPD, S_EMIT
  } state_t;

  localparam logic [IDX_W-1:0] LAST = IDX_W'(FLOWS - 1);

  state_t              state;
  item_t               item;
  entry_t              mem [FLOWS];
  entry_t              rdata;
  entry_t              hit_data;
  entry_t              wdata;
  logic [IDX_W-1:0]    waddr;
  logic                we;
  logic [FLOWS-1:0]    valid;
  logic [IDX_W-1:0]    scan;
  logic                rv;
  logic [IDX_W-1:0]    ri;
  logic                hit_found;
  logic [IDX_W-1:0]    hit_idx;
  logic                free_found;
  logic [IDX_W-1:0]    free_idx;

  logic                div_start;
  logic [TIME_W-1:0]   div_in;
  logic                div_done;
  logic [TIME_W-1:0]   div_quot;
  logic [CARRY_W-1:0]  div_rem;

  logic [TIME_W-1:0]   elapsed;
  logic [TIME_W-1:0]   whole;
  logic [CARRY_W-1:0]  frac;
  logic [45:0]         big;
  logic [59:0]         prod;
  logic [30:0]         add_amt;
  logic                sat;
  logic [31:0]         sum;
  logic [BUCKET_W-1:0] clamped;

  logic                p_admit;
  outcome_t            p_outcome;
  logic [BUCKET_W-1:0] p_tokens;
  logic [CNT_W-1:0]    p_sent;
  logic [CNT_W-1:0]    p_drop;

  pftb_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_in),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  assign pop = (state == S_IDLE) && head.valid;

  // elapsed time including the carried fraction of a second
  assign elapsed = item.now - hit_data.stamp + {{(TIME_W-CARRY_W){1'b0}}, hit_data.carry};
  assign prod    = 60'(frac) * 60'(refill_rate);

  always_comb begin
    div_start = 1'b0;
    div_in    = elapsed;
    if (state == S_DECIDE && hit_found) begin
      div_start = 1'b1;
    end else if (state == S_MUL) begin
      div_start = 1'b1;
      div_in    = {{(TIME_W-60){1'b0}}, prod};
    end
  end

  // refill saturation and token clamp
  assign sat = ((refill_rate != '0) && (whole[TIME_W-1:16] != '0))
               || (big >= {30'b0, bucket_size});
  assign sum = {16'b0, hit_data.tokens} + {1'b0, add_amt};
  assign clamped = (sum > {16'b0, bucket_size}) ? bucket_size : sum[BUCKET_W-1:0];

  // table write data
  always_comb begin
    we    = 1'b0;
    waddr = hit_idx;
    wdata = hit_data;
    if (state == S_DECIDE && !hit_found && free_found) begin
      we            = 1'b1;
      waddr         = free_idx;
      wdata.port    = item.port;
      wdata.stamp   = item.now;
      wdata.carry   = '0;
      wdata.tokens  = bucket_size - 1'b1;
      wdata.sent    = CNT_W'(1);
      wdata.dropped = '0;
    end else if (state == S_UPD) begin
      we          = 1'b1;
      wdata.stamp = item.now;
      wdata.carry = frac;
      if (clamped != '0) begin
        wdata.tokens = clamped - 1'b1;
        wdata.sent   = hit_data.sent + 1'b1;
      end else begin
        wdata.tokens  = '0;
        wdata.dropped = hit_data.dropped + 1'b1;
      end
    end
  end

  // flow table memory
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[scan];
  end

  // sequencer and registered result
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      valid      <= '0;
      rv         <= 1'b0;
      res.valid  <= 1'b0;
      scan       <= '0;
      hit_found  <= 1'b0;
      free_found <= 1'b0;
    end else begin
      if (res.valid && res.ready && state != S_EMIT) begin
        res.valid <= 1'b0;
      end

      // compare the entry read in the previous cycle
      rv <= (state == S_SRCH);
      ri <= scan;
      if (rv) begin
        if (valid[ri]) begin
          if (!hit_found && rdata.port == item.port) begin
            hit_found <= 1'b1;
            hit_idx   <= ri;
            hit_data  <= rdata;
          end
        end else if (!free_found) begin
          free_found <= 1'b1;
          free_idx   <= ri;
        end
      end

      unique case (state)
        S_IDLE: begin
          if (head.valid) begin
            item       <= head.item;
            scan       <= '0;
            hit_found  <= 1'b0;
            free_found <= 1'b0;
            if (head.item.disabled) begin
              p_admit   <= 1'b0;
              p_outcome <= OUT_DISABLED;
              p_tokens  <= '0;
              p_sent    <= '0;
              p_drop    <= '0;
              state     <= S_EMIT;
            end else begin
              state <= S_SRCH;
            end
          end
        end
        S_SRCH: begin
          if (scan == LAST) begin
            state <= S_SCHK;
          end else begin
            scan <= scan + 1'b1;
          end
        end
        S_SCHK: begin
          state <= S_DECIDE;
        end
        S_DECIDE: begin
          if (hit_found) begin
            state <= S_DIV1;
          end else if (free_found) begin
            valid[free_idx] <= 1'b1;
            p_admit   <= 1'b1;
            p_outcome <= OUT_NEW_FLOW;
            p_tokens  <= bucket_size - 1'b1;
            p_sent    <= CNT_W'(1);
            p_drop    <= '0;
            state     <= S_EMIT;
          end else begin
            p_admit   <= 1'b1;
            p_outcome <= OUT_TABLE_FULL;
            p_tokens  <= '0;
            p_sent    <= '0;
            p_drop    <= '0;
            state     <= S_EMIT;
          end
        end
        S_DIV1: begin
          if (div_done) begin
            whole <= div_quot;
            frac  <= div_rem;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          big   <= 46'(whole[15:0]) * 46'(refill_rate);
          state <= S_DIV2;
        end
        S_DIV2: begin
          if (div_done) begin
            if (sat) begin
              add_amt <= {15'b0, bucket_size};
            end else begin
              add_amt <= 31'(big) + {1'b0, div_quot[CARRY_W-1:0]};
            end
            state <= S_UPD;
          end
        end
        S_UPD: begin
          p_admit   <= (clamped != '0);
          p_outcome <= (clamped != '0) ? OUT_KNOWN_ADMIT : OUT_KNOWN_DROP;
          p_tokens  <= wdata.tokens;
          p_sent    <= wdata.sent;
          p_drop    <= wdata.dropped;
          state     <= S_EMIT;
        end
        S_EMIT: begin
          if (!res.valid || res.ready) begin
            res.valid       <= 1'b1;
            res.admit       <= p_admit;
            res.outcome     <= p_outcome;
            res.tokens_left <= p_tokens;
            res.sent_count  <= p_sent;
            res.drop_count  <= p_drop;
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== src/per_flow_token_bucket_policer_unit.sv =====
// a known flow scans the table one entry per cycle through the memory read port,
// then does two divisions by one second in the divider
// new and full packets skip the divisions; disabled packets skip the scan too
// throughput: one packet at a time in the back end, set by the scan and the divider
// a two-entry queue in front keeps accepting while the back end is busy, until it is full
// reset: synchronous, clears all flow valid bits, queue and result; registers to 100 and 1000
module per_flow_token_bucket_policer_unit import pftb_pkg::*; (
  input logic      clk,
  input logic      rst,
  pftb_pkt_if.sink pkt,
  pftb_res_if.source res,
  pftb_cfg_if.sink cfg
);

  logic [BUCKET_W-1:0] bucket_size;
  logic [RATE_W-1:0]   refill_rate;
  queue_head_t         head;
  logic                pop;

  assign cfg.ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_size <= BUCKET_RESET;
      refill_rate <= RATE_RESET;
    end else if (cfg.valid && cfg.ready) begin
      if (cfg.index == REG_BUCKET) begin
        bucket_size <= cfg.data[BUCKET_W-1:0];
      end else if (cfg.index == REG_RATE) begin
        refill_rate <= cfg.data[RATE_W-1:0];
      end
    end
  end

  pftb_front u_front (
    .clk         (clk),
    .rst         (rst),
    .pkt         (pkt),
    .bucket_size (bucket_size),
    .head        (head),
    .pop         (pop)
  );

  pftb_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .pop         (pop),
    .bucket_size (bucket_size),
    .refill_rate (refill_rate),
    .res         (res)
  );

  // admit agrees with the outcome code
  a_admit: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (res.admit == (res.outcome != OUT_KNOWN_DROP
                                 && res.outcome != OUT_DISABLED)))
    else $error("admit does not match outcome");

  // a new flow starts with one sent packet and no drops
  a_new: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.outcome == OUT_NEW_FLOW) |-> (res.sent_count == CNT_W'(1)
                                                    && res.drop_count == '0))
    else $error("new flow counters wrong");

  // pop only when the queue has an item
  a_pop: assert property (@(posedge clk) disable iff (rst) pop |-> head.valid)
    else $error("pop from empty queue");

  // no result right after reset
  a_rst: assert property (@(posedge clk) rst |=> !res.valid)
    else $error("result valid after reset");

endmodule
